// File: rtl/dctwg_pkg.sv
// Shared types, constants and the quarter-wave sine table for the dual channel
// table waveform generator. No dependencies; dctwg_shape and the top level import it.
package dctwg_pkg;

  localparam int NUM_CH      = 2;
  localparam int SAMPLE_W    = 8;
  localparam int PHASE_W     = 9;
  localparam int TICKS_W     = 16;
  localparam int WAVE_W      = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Q1.14 sine magnitude table over 0..90 degrees.
  localparam int SINE_W      = 15;
  localparam int SINE_FRAC   = 14;
  localparam int QUARTER_LEN = 91;
  localparam int QIDX_W      = 7;

  localparam logic [PHASE_W-1:0] DEG_QUARTER = PHASE_W'(90);
  localparam logic [PHASE_W-1:0] DEG_HALF    = PHASE_W'(180);
  localparam logic [PHASE_W-1:0] DEG_3Q      = PHASE_W'(270);
  localparam logic [PHASE_W-1:0] DEG_FULL    = PHASE_W'(360);

  localparam logic [SAMPLE_W-1:0] AMP_RESET = SAMPLE_W'(210);

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_SQUARE = 2'd2
  } wave_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CH1_WAVEFORM  = 3'd0,
    REG_CH1_TICKS     = 3'd1,
    REG_CH1_AMPLITUDE = 3'd2,
    REG_CH2_WAVEFORM  = 3'd3,
    REG_CH2_TICKS     = 3'd4,
    REG_CH2_AMPLITUDE = 3'd5
  } reg_index_t;

  // Stage load strobes and the emit flag handed to each channel's shaper.
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic emit;
  } shape_ctrl_t;

  localparam logic [SINE_W-1:0] QUARTER_SINE [QUARTER_LEN] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  function automatic logic [SINE_W-1:0] quarter_sine(input logic [QIDX_W-1:0] idx);
    return (idx < QIDX_W'(QUARTER_LEN)) ? QUARTER_SINE[idx] : '0;
  endfunction

endpackage

// File: rtl/dctwg_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered
// read. No package dependencies.
module dctwg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/dctwg_shape.sv
// Per-channel sample shaper: folds the phase into the quarter-wave table, then
// forms the sine, sawtooth and square levels over two registered stages.
// Depends on dctwg_pkg.
module dctwg_shape #(
  parameter int SAMPLES = 360
) (
  input  logic                           clk,
  input  dctwg_pkg::shape_ctrl_t         ctrl,
  input  logic [dctwg_pkg::PHASE_W-1:0]  phase,
  input  logic [dctwg_pkg::WAVE_W-1:0]   waveform,
  input  logic [dctwg_pkg::SAMPLE_W-1:0] amplitude,
  output logic                           update,
  output logic [dctwg_pkg::SAMPLE_W-1:0] level
);
  import dctwg_pkg::*;

  // Exact floor division by SAMPLES through a reciprocal with one spare bit.
  localparam int PROD_W  = SAMPLE_W + PHASE_W;
  localparam int SHIFT   = PROD_W + $clog2(SAMPLES);
  localparam int MUL_W   = PROD_W + 2;
  localparam int FULL_W  = PROD_W + MUL_W;
  localparam longint MUL_L = ((longint'(1) << SHIFT) + SAMPLES - 1) / SAMPLES;
  localparam logic [MUL_W-1:0]   SAW_MUL = MUL_W'(MUL_L);
  localparam logic [PHASE_W-1:0] HALF_PERIOD = PHASE_W'(SAMPLES / 2);
  localparam int HALF_W   = SAMPLE_W - 1;
  localparam int SPROD_W  = HALF_W + SINE_W;

  logic [PHASE_W-1:0] deg;
  logic [QIDX_W-1:0]  fold_idx;
  logic               fold_neg;

  always_comb begin
    deg = (phase >= DEG_FULL) ? phase - DEG_FULL : phase;
    if (deg <= DEG_QUARTER) begin
      fold_idx = QIDX_W'(deg);
      fold_neg = 1'b0;
    end else if (deg <= DEG_HALF) begin
      fold_idx = QIDX_W'(DEG_HALF - deg);
      fold_neg = 1'b0;
    end else if (deg <= DEG_3Q) begin
      fold_idx = QIDX_W'(deg - DEG_HALF);
      fold_neg = 1'b1;
    end else begin
      fold_idx = QIDX_W'(DEG_FULL - deg);
      fold_neg = 1'b1;
    end
  end

  // Stage two: table lookup and the two products.
  logic               emit2;
  logic               neg2;
  logic [QIDX_W-1:0]  idx2;
  logic [PHASE_W-1:0] phase2;

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      emit2  <= ctrl.emit;
      neg2   <= fold_neg;
      idx2   <= fold_idx;
      phase2 <= phase;
    end
  end

  logic [HALF_W-1:0]   half_amp;
  logic [SINE_W-1:0]   mag;
  logic [SPROD_W-1:0]  sine_prod_d;
  logic [PROD_W-1:0]   saw_prod_d;
  logic [SAMPLE_W-1:0] square_d;

  always_comb begin
    half_amp    = amplitude[SAMPLE_W-1:1];
    mag         = quarter_sine(idx2);
    sine_prod_d = SPROD_W'(half_amp) * SPROD_W'(mag);
    saw_prod_d  = PROD_W'(amplitude) * PROD_W'(phase2);
    square_d    = (phase2 < HALF_PERIOD) ? amplitude : '0;
  end

  // Stage three: finish the sine, scale the sawtooth, pick the shape.
  logic                emit3;
  logic                neg3;
  logic [SPROD_W-1:0]  sine_prod3;
  logic [PROD_W-1:0]   saw_prod3;
  logic [SAMPLE_W-1:0] square3;

  always_ff @(posedge clk) begin
    if (ctrl.ld3) begin
      emit3      <= emit2;
      neg3       <= neg2;
      sine_prod3 <= sine_prod_d;
      saw_prod3  <= saw_prod_d;
      square3    <= square_d;
    end
  end

  logic [SAMPLE_W-1:0] sine_q;
  logic [SAMPLE_W-1:0] sine_level;
  logic [FULL_W-1:0]   saw_full;
  logic [SAMPLE_W-1:0] saw_level;

  always_comb begin
    sine_q     = sine_prod3[SINE_FRAC +: SAMPLE_W];
    sine_level = neg3 ? SAMPLE_W'(half_amp) - sine_q : SAMPLE_W'(half_amp) + sine_q;
    saw_full   = FULL_W'(saw_prod3) * FULL_W'(SAW_MUL);
    saw_level  = saw_full[SHIFT +: SAMPLE_W];
    case (waveform)
      WAVE_SINE: begin
        level  = sine_level;
        update = emit3;
      end
      WAVE_SAW: begin
        level  = saw_level;
        update = emit3;
      end
      WAVE_SQUARE: begin
        level  = square3;
        update = emit3;
      end
      default: begin
        // Unassigned shape: the channel keeps its level.
        level  = sine_level;
        update = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/dual_channel_table_waveform_generator_top.sv
// Dual channel table waveform generator, top level.
// Depends on dctwg_pkg, dctwg_ram and dctwg_shape.
//
// One tick item is accepted per clock while in_ready is high; out_ready can stall
// it. Each item moves from stage one through stages two and three to the output
// register. Throughput is one item per cycle while out_ready does not stall, set
// by the read-modify-write of the divider and phase memory, whose back-to-back
// accesses are forwarded. The memory needs no clearing pass after reset: a written
// flag makes it read as zero until the first tick is stored. Configuration writes
// take effect at once and should be made while no tick is in flight.
module dual_channel_table_waveform_generator_top #(
  parameter int SAMPLES      = 360,
  parameter int DIVIDER_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              tick,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dctwg_pkg::SAMPLE_W-1:0]    ch1_sample,
  output logic                              ch1_update,
  output logic [dctwg_pkg::SAMPLE_W-1:0]    ch2_sample,
  output logic                              ch2_update,
  input  logic                              cfg_we,
  input  logic [dctwg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dctwg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dctwg_pkg::*;

  localparam int CMP_W = (DIVIDER_BITS > TICKS_W) ? DIVIDER_BITS : TICKS_W;
  localparam logic [DIVIDER_BITS-1:0] DIV_MAX = '1;

  typedef struct packed {
    logic [DIVIDER_BITS-1:0] divider;
    logic [PHASE_W-1:0]      phase;
  } chan_state_t;

  localparam int WORD_W = NUM_CH * $bits(chan_state_t);

  // Configuration registers.
  logic [WAVE_W-1:0]   wave      [NUM_CH];
  logic [TICKS_W-1:0]  ticks     [NUM_CH];
  logic [SAMPLE_W-1:0] amplitude [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        wave[c]      <= WAVE_SINE;
        ticks[c]     <= '0;
        amplitude[c] <= AMP_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CH1_WAVEFORM:  wave[0]      <= cfg_data[WAVE_W-1:0];
        REG_CH1_TICKS:     ticks[0]     <= cfg_data[TICKS_W-1:0];
        REG_CH1_AMPLITUDE: amplitude[0] <= cfg_data[SAMPLE_W-1:0];
        REG_CH2_WAVEFORM:  wave[1]      <= cfg_data[WAVE_W-1:0];
        REG_CH2_TICKS:     ticks[1]     <= cfg_data[TICKS_W-1:0];
        REG_CH2_AMPLITUDE: amplitude[1] <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline occupancy and flow control; each stage takes a transfer when it is
  // empty or its occupant moves on in the same cycle.
  logic v1, v2, v3, vo;
  logic tick1;
  logic accept, move1, move2, move3;

  always_comb begin
    move3    = v3 && (!vo || out_ready);
    move2    = v2 && (!v3 || move3);
    move1    = v1 && (!v2 || move2);
    in_ready = !v1 || move1;
    accept   = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      v1 <= accept || (v1 && !move1);
      v2 <= move1 || (v2 && !move2);
      v3 <= move2 || (v3 && !move3);
      vo <= move3 || (vo && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick1 <= tick;
    end
  end

  // Divider and phase memory with write-to-read forwarding.
  chan_state_t [NUM_CH-1:0] rd_word;
  chan_state_t [NUM_CH-1:0] wr_word;
  chan_state_t [NUM_CH-1:0] fwd_word;
  chan_state_t [NUM_CH-1:0] cur_word;
  logic ram_we;
  logic written, rd_ok, fwd;

  assign ram_we = move1 && tick1;

  dctwg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (1)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ('0),
    .wdata (wr_word),
    .re    (accept),
    .raddr ('0),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= 1'b0;
      rd_ok   <= 1'b0;
      fwd     <= 1'b0;
    end else begin
      if (ram_we) begin
        written <= 1'b1;
      end
      if (accept) begin
        rd_ok <= written;
        // The read issued at this edge misses a write made at the same edge.
        fwd   <= ram_we;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_word <= wr_word;
    end
  end

  assign cur_word = fwd ? fwd_word : (rd_ok ? rd_word : '0);

  // Per-channel divider and phase update, then the shaper.
  logic                emit    [NUM_CH];
  logic                lvl_upd [NUM_CH];
  logic [SAMPLE_W-1:0] lvl     [NUM_CH];

  for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
    logic [DIVIDER_BITS-1:0] div_inc;
    logic [PHASE_W:0]        phase_inc;
    logic                    hit;
    shape_ctrl_t             ctrl;

    always_comb begin
      div_inc   = (cur_word[c].divider == DIV_MAX) ? DIV_MAX
                                                   : cur_word[c].divider + 1'b1;
      hit       = (CMP_W'(div_inc) >= CMP_W'(ticks[c])) || (div_inc == DIV_MAX);
      phase_inc = {1'b0, cur_word[c].phase} + 1'b1;
      emit[c]   = tick1 && hit;
      wr_word[c].divider = hit ? '0 : div_inc;
      if (!hit) begin
        wr_word[c].phase = cur_word[c].phase;
      end else if (phase_inc >= (PHASE_W+1)'(SAMPLES)) begin
        wr_word[c].phase = '0;
      end else begin
        wr_word[c].phase = phase_inc[PHASE_W-1:0];
      end
      ctrl.ld2  = move1;
      ctrl.ld3  = move2;
      ctrl.emit = emit[c];
    end

    dctwg_shape #(
      .SAMPLES (SAMPLES)
    ) u_shape (
      .clk       (clk),
      .ctrl      (ctrl),
      .phase     (cur_word[c].phase),
      .waveform  (wave[c]),
      .amplitude (amplitude[c]),
      .update    (lvl_upd[c]),
      .level     (lvl[c])
    );
  end

  // Output register; the sample registers also hold each channel's level.
  logic [SAMPLE_W-1:0] sample_q [NUM_CH];
  logic                upd_q    [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sample_q[c] <= '0;
        upd_q[c]    <= 1'b0;
      end
    end else if (move3) begin
      for (int c = 0; c < NUM_CH; c++) begin
        upd_q[c] <= lvl_upd[c];
        if (lvl_upd[c]) begin
          sample_q[c] <= lvl[c];
        end
      end
    end
  end

  assign out_valid  = vo;
  assign ch1_sample = sample_q[0];
  assign ch1_update = upd_q[0];
  assign ch2_sample = sample_q[1];
  assign ch2_update = upd_q[1];

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (cur_word[0].phase < PHASE_W'(SAMPLES)) && (cur_word[1].phase < PHASE_W'(SAMPLES)))
    else $error("stored phase index reached the period length");

  a_short_period: assert property (@(posedge clk) disable iff (rst)
    v1 && tick1 && (ticks[0] <= TICKS_W'(1)) && (ticks[1] <= TICKS_W'(1))
      |-> emit[0] && emit[1])
    else $error("channel failed to emit with a period of one tick");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    fwd |-> written)
    else $error("forwarding selected before any state write");

  a_update_shape: assert property (@(posedge clk) disable iff (rst)
    vo && ch1_update |->
      (wave[0] == WAVE_SINE) || (wave[0] == WAVE_SAW) || (wave[0] == WAVE_SQUARE))
    else $error("channel one updated with an unassigned shape");

endmodule
